>>> sv/srsp_pkg.sv
// ----------------------------------------------------------------------------
// srsp_pkg
// Shared types and codes for the swap-remove slot pool.
// ----------------------------------------------------------------------------
package srsp_pkg;

  localparam int POOL_COUNT_DEF     = 2;
  localparam int SLOTS_PER_POOL_DEF = 64;

  localparam int POOL_W  = 2;   // pool field
  localparam int SLOT_W  = 6;   // slot ids and positions
  localparam int CNT_W   = 7;   // active / created counts
  localparam int STAT_W  = 2;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_POOL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FREE      = 2'd3;

  // count update request from the control logic to the count file
  typedef struct packed {
    logic              act_inc;
    logic              act_dec;
    logic              cre_inc;
    logic [POOL_W-1:0] pool;
  } count_upd_t;

endpackage

>>> sv/srsp_ram.sv
// ----------------------------------------------------------------------------
// srsp_ram
// Single-port synchronous RAM, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module srsp_ram #(
  parameter int DEPTH  = 128,
  parameter int IDX_W  = 7,
  parameter int DATA_W = 6
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [IDX_W-1:0]  addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/srsp_counts.sv
// ----------------------------------------------------------------------------
// srsp_counts
// Per-pool active and created counts, looked up by pool, updated by request.
// ----------------------------------------------------------------------------
module srsp_counts #(
  parameter int POOL_COUNT = srsp_pkg::POOL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [srsp_pkg::POOL_W-1:0]    sel_pool,
  output logic [srsp_pkg::CNT_W-1:0]     act,
  output logic [srsp_pkg::CNT_W-1:0]     cre,
  input  srsp_pkg::count_upd_t           upd
);

  logic [srsp_pkg::CNT_W-1:0] act_r   [POOL_COUNT];
  logic [srsp_pkg::CNT_W-1:0] cre_r   [POOL_COUNT];
  logic [srsp_pkg::CNT_W-1:0] act_nxt [POOL_COUNT];
  logic [srsp_pkg::CNT_W-1:0] cre_nxt [POOL_COUNT];

  always_comb begin
    act = '0;
    cre = '0;
    for (int i = 0; i < POOL_COUNT; i++) begin
      if (sel_pool == srsp_pkg::POOL_W'(i)) begin
        act = act_r[i];
        cre = cre_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < POOL_COUNT; i++) begin
      act_nxt[i] = act_r[i];
      cre_nxt[i] = cre_r[i];
      if (upd.pool == srsp_pkg::POOL_W'(i)) begin
        if (upd.act_inc) begin
          act_nxt[i] = act_r[i] + 1'b1;
        end else if (upd.act_dec) begin
          act_nxt[i] = act_r[i] - 1'b1;
        end
        if (upd.cre_inc) begin
          cre_nxt[i] = cre_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < POOL_COUNT; i++) begin
      if (!rst_n) begin
        act_r[i] <= '0;
        cre_r[i] <= '0;
      end else begin
        act_r[i] <= act_nxt[i];
        cre_r[i] <= cre_nxt[i];
      end
    end
  end

endmodule

>>> sv/swap_remove_slot_pool.sv
// ----------------------------------------------------------------------------
// swap_remove_slot_pool
// Dense slot pools: allocate from the front, release by swap with last live.
// ----------------------------------------------------------------------------
//  channel   ports                                         handshake
//  input     in_mode, in_pool, in_handle                   start & !busy
//  result    out_handle_out, out_status, out_live_count    out_valid, 1 cycle
//
//  Allocate and every rejected request pass through accept and execute; release of
//  a live slot adds a second write state, as each single-port position RAM takes
//  two writes for the swap. The result strobe follows the execute cycle.
//  Reset clears counts and control at once; RAM contents need no clearing.
//  The receiver cannot stall; busy alone holds off new requests.
module swap_remove_slot_pool #(
  parameter int POOL_COUNT     = srsp_pkg::POOL_COUNT_DEF,
  parameter int SLOTS_PER_POOL = srsp_pkg::SLOTS_PER_POOL_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [srsp_pkg::POOL_W-1:0]   in_pool,
  input  logic [srsp_pkg::SLOT_W-1:0]   in_handle,
  output logic                          out_valid,
  output logic [srsp_pkg::SLOT_W-1:0]   out_handle_out,
  output logic [srsp_pkg::STAT_W-1:0]   out_status,
  output logic [srsp_pkg::CNT_W-1:0]    out_live_count
);

  localparam int DEPTH = POOL_COUNT * SLOTS_PER_POOL;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = srsp_pkg::SLOT_W;
  localparam int CW    = srsp_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WR2  = 2'd2;

  function automatic logic [IDX_W-1:0] mem_addr(input logic [srsp_pkg::POOL_W-1:0] p,
                                                input logic [CW-1:0] off);
    return IDX_W'(int'(p) * SLOTS_PER_POOL + int'(off));
  endfunction

  logic [1:0]                  state_r, state_nxt;
  logic                        req_mode_r;
  logic [srsp_pkg::POOL_W-1:0] req_pool_r;
  logic [SW-1:0]               req_handle_r;
  logic [CW-1:0]               req_act_r, req_cre_r;
  logic                        req_pool_ok_r;

  logic                        out_valid_r;
  logic [SW-1:0]               out_handle_r;
  logic [srsp_pkg::STAT_W-1:0] out_status_r;
  logic [CW-1:0]               out_live_r;

  logic                        accept;
  logic [CW-1:0]               act_cur, cre_cur;
  srsp_pkg::count_upd_t        upd;

  logic                        sap_en, sap_we, pos_en, pos_we;
  logic [IDX_W-1:0]            sap_addr, pos_addr;
  logic [SW-1:0]               sap_wdata, pos_wdata, sap_rdata, pos_rdata;

  logic                        exhausted, fresh, bad_handle, bad_pos, rel_ok;
  logic [CW-1:0]               last;
  logic [SW-1:0]               alloc_id;
  logic                        res_load;
  logic [SW-1:0]               res_handle;
  logic [srsp_pkg::STAT_W-1:0] res_status;
  logic [CW-1:0]               res_live;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  srsp_counts #(
    .POOL_COUNT (POOL_COUNT)
  ) u_counts (
    .clk      (clk),
    .rst_n    (rst_n),
    .sel_pool (in_pool),
    .act      (act_cur),
    .cre      (cre_cur),
    .upd      (upd)
  );

  srsp_ram #(.DEPTH(DEPTH), .IDX_W(IDX_W), .DATA_W(SW)) u_slot_at_pos (
    .clk   (clk),
    .en    (sap_en),
    .we    (sap_we),
    .addr  (sap_addr),
    .wdata (sap_wdata),
    .rdata (sap_rdata)
  );

  srsp_ram #(.DEPTH(DEPTH), .IDX_W(IDX_W), .DATA_W(SW)) u_pos_of_slot (
    .clk   (clk),
    .en    (pos_en),
    .we    (pos_we),
    .addr  (pos_addr),
    .wdata (pos_wdata),
    .rdata (pos_rdata)
  );

  // decisions during execute, from the request and the RAM read data
  always_comb begin
    last       = req_act_r - 1'b1;
    exhausted  = (req_act_r >= CW'(SLOTS_PER_POOL));
    fresh      = (req_act_r >= req_cre_r);
    alloc_id   = fresh ? req_cre_r[SW-1:0] : sap_rdata;
    bad_handle = ({1'b0, req_handle_r} >= req_cre_r);
    bad_pos    = ({1'b0, pos_rdata} >= req_act_r);
    rel_ok     = req_pool_ok_r && (req_mode_r == srsp_pkg::MODE_RELEASE) &&
                 !bad_handle && !bad_pos;

    res_handle = req_handle_r;
    res_status = srsp_pkg::STAT_OK;
    res_live   = req_act_r;
    if (!req_pool_ok_r) begin
      res_handle = '0;
      res_status = srsp_pkg::STAT_BAD_POOL;
      res_live   = '0;
    end else if (req_mode_r == srsp_pkg::MODE_ALLOC) begin
      if (exhausted) begin
        res_handle = '0;
        res_status = srsp_pkg::STAT_EXHAUSTED;
      end else begin
        res_handle = alloc_id;
        res_live   = req_act_r + 1'b1;
      end
    end else if (bad_handle || bad_pos) begin
      res_status = srsp_pkg::STAT_FREE;
    end else begin
      res_live = last;
    end
  end

  // RAM port and count control
  always_comb begin
    sap_en    = 1'b0;
    sap_we    = 1'b0;
    sap_addr  = '0;
    sap_wdata = '0;
    pos_en    = 1'b0;
    pos_we    = 1'b0;
    pos_addr  = '0;
    pos_wdata = '0;
    upd       = '{act_inc: 1'b0, act_dec: 1'b0, cre_inc: 1'b0, pool: req_pool_r};
    state_nxt = state_r;
    res_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sap_en    = 1'b1;
          pos_en    = 1'b1;
          pos_addr  = mem_addr(in_pool, CW'(in_handle));
          sap_addr  = (in_mode == srsp_pkg::MODE_ALLOC) ? mem_addr(in_pool, act_cur)
                                                        : mem_addr(in_pool, act_cur - 1'b1);
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_load  = 1'b1;
        state_nxt = ST_IDLE;
        if (req_pool_ok_r && req_mode_r == srsp_pkg::MODE_ALLOC && !exhausted) begin
          upd.act_inc = 1'b1;
          if (fresh) begin
            upd.cre_inc = 1'b1;
            sap_en      = 1'b1;
            sap_we      = 1'b1;
            sap_addr    = mem_addr(req_pool_r, req_act_r);
            sap_wdata   = req_cre_r[SW-1:0];
            pos_en      = 1'b1;
            pos_we      = 1'b1;
            pos_addr    = mem_addr(req_pool_r, req_cre_r);
            pos_wdata   = req_act_r[SW-1:0];
          end
        end else if (rel_ok) begin
          // move the last live slot into the released position
          upd.act_dec = 1'b1;
          sap_en      = 1'b1;
          sap_we      = 1'b1;
          sap_addr    = mem_addr(req_pool_r, CW'(pos_rdata));
          sap_wdata   = sap_rdata;
          pos_en      = 1'b1;
          pos_we      = 1'b1;
          pos_addr    = mem_addr(req_pool_r, CW'(sap_rdata));
          pos_wdata   = pos_rdata;
          state_nxt   = ST_WR2;
        end
      end
      ST_WR2: begin
        sap_en    = 1'b1;
        sap_we    = 1'b1;
        sap_addr  = mem_addr(req_pool_r, last);
        sap_wdata = req_handle_r;
        pos_en    = 1'b1;
        pos_we    = 1'b1;
        pos_addr  = mem_addr(req_pool_r, CW'(req_handle_r));
        pos_wdata = last[SW-1:0];
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r    <= in_mode;
      req_pool_r    <= in_pool;
      req_handle_r  <= in_handle;
      req_act_r     <= act_cur;
      req_cre_r     <= cre_cur;
      req_pool_ok_r <= (int'(in_pool) < POOL_COUNT);
    end
    if (res_load) begin
      out_handle_r <= res_handle;
      out_status_r <= res_status;
      out_live_r   <= res_live;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_status     = out_status_r;
  assign out_live_count = out_live_r;

endmodule

>>> sv/srsp_checker.sv
// ----------------------------------------------------------------------------
// srsp_checker
// Port-level timing and result checks for the slot pool, bound to the top.
// ----------------------------------------------------------------------------
module srsp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [srsp_pkg::SLOT_W-1:0]   out_handle_out,
  input logic [srsp_pkg::STAT_W-1:0]   out_status,
  input logic [srsp_pkg::CNT_W-1:0]    out_live_count
);

  // every transfer in gives a result strobe, registered from the execute state
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing after input transfer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_bad_pool_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == srsp_pkg::STAT_BAD_POOL) |->
      (out_handle_out == '0 && out_live_count == '0))
    else $error("bad pool result carries data");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("control not cleared by reset");

endmodule

bind swap_remove_slot_pool srsp_checker u_srsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_handle_out (out_handle_out),
  .out_status     (out_status),
  .out_live_count (out_live_count)
);
